// File: rtl/sitrd_pkg.sv
package sitrd_pkg;

    localparam int DEF_MAX_RADIX  = 16;
    localparam int DEF_VALUE_BITS = 32;

    localparam int RADIX_BITS     = 5;
    localparam int DIGIT_BITS     = 4;
    localparam int CHAR_BITS      = 8;
    localparam int ALPHA_CHARS    = 16;
    localparam int CFG_BITS       = 64;
    localparam int CFG_INDEX_BITS = 2;

    // register indexes on the config port
    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_HIGH = 2'd2;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET      = 5'd10;
    localparam logic [CFG_BITS-1:0]   ALPHA_LOW_RESET  = 64'd3978425819141910832; // "01234567"
    localparam logic [CFG_BITS-1:0]   ALPHA_HIGH_RESET = 64'd14648;               // "89"

    localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'd13;

    typedef struct packed {
        logic                  done;
        logic [DIGIT_BITS-1:0] remainder;
    } div_status_t;

    // byte k of the 16-character alphabet, digit 0 in the low byte of lo
    function automatic logic [CHAR_BITS-1:0] alpha_char(
        input logic [CFG_BITS-1:0]   lo,
        input logic [CFG_BITS-1:0]   hi,
        input logic [DIGIT_BITS-1:0] k
    );
        logic [CFG_BITS-1:0] word;
        word = k[DIGIT_BITS-1] ? hi : lo;
        return word[k[DIGIT_BITS-2:0]*CHAR_BITS +: CHAR_BITS];
    endfunction

endpackage

// File: rtl/sitrd_check.sv
module sitrd_check
    import sitrd_pkg::*;
#(
    parameter int MAX_RADIX = DEF_MAX_RADIX
)
(
    input  logic [RADIX_BITS-1:0] radix,
    input  logic [CFG_BITS-1:0]   alphabet_low,
    input  logic [CFG_BITS-1:0]   alphabet_high,
    output logic                  invalid
);

    logic [CHAR_BITS-1:0] chars [ALPHA_CHARS];
    logic                 bad;

    always_comb
    begin
        for (int i = 0; i < ALPHA_CHARS; i++)
        begin
            chars[i] = alpha_char(alphabet_low, alphabet_high, DIGIT_BITS'(i));
        end
        bad = (radix < RADIX_BITS'(2)) || (radix > RADIX_BITS'(MAX_RADIX));
        for (int i = 0; i < ALPHA_CHARS; i++)
        begin
            if (RADIX_BITS'(i) < radix)
            begin
                if (chars[i] == CHAR_NUL || chars[i] == CHAR_MINUS ||
                    chars[i] == CHAR_PLUS || chars[i] == CHAR_SPACE ||
                    (chars[i] >= CHAR_TAB && chars[i] <= CHAR_CR))
                begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < ALPHA_CHARS; j++)
                begin
                    if (RADIX_BITS'(j) < radix && chars[j] == chars[i])
                    begin
                        bad = 1'b1;
                    end
                end
            end
        end
        invalid = bad;
    end

endmodule

// File: rtl/sitrd_div.sv
module sitrd_div
    import sitrd_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [RADIX_BITS-1:0] divisor,
    output logic [VALUE_BITS-1:0] quotient,
    output div_status_t           status
);

    localparam int STEP_W = $clog2(VALUE_BITS);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [VALUE_BITS-1:0] work_reg;
    logic [DIGIT_BITS-1:0] rem_reg;

    logic [RADIX_BITS-1:0] shifted;
    logic [RADIX_BITS-1:0] diff;
    logic                  ge;

    // one restoring step: remainder stays below the divisor, so 4 bits hold it
    always_comb
    begin
        shifted = {rem_reg, work_reg[VALUE_BITS-1]};
        ge      = (shifted >= divisor);
        diff    = shifted - divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(VALUE_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[VALUE_BITS-2:0], ge};
            rem_reg  <= ge ? diff[DIGIT_BITS-1:0] : shifted[DIGIT_BITS-1:0];
        end
    end

    assign quotient         = work_reg;
    assign status.done      = done_reg;
    assign status.remainder = rem_reg;

endmodule

// File: rtl/signed_int_to_radix_digits.sv
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall   value
// result    out        out_valid / out_stall character, last, invalid_base
// config    in         cfg_we               cfg_index, cfg_data
//
// A request is taken only in idle. Each digit is then produced by one
// division in the shared bit-serial divider; then one character leaves per
// cycle while out_stall is low. A bad radix or alphabet moves to the error
// state, which loads one error result once the result register is free.
// out_stall holds the result register and the emit and error states of the
// sequencer; no request is taken until the last character is loaded.
// Reset restores radix 10 and the "0123456789" alphabet.
module signed_int_to_radix_digits
    import sitrd_pkg::*;
#(
    parameter int MAX_RADIX  = DEF_MAX_RADIX,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [CHAR_BITS-1:0]        character,
    output logic                        last,
    output logic                        invalid_base,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_BITS-1:0]         cfg_data
);

    localparam int DIGIT_SLOTS = VALUE_BITS;          // radix 2 worst case
    localparam int IDX_W       = $clog2(DIGIT_SLOTS);
    localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    // configuration
    logic [RADIX_BITS-1:0] radix_reg;
    logic [CFG_BITS-1:0]   alpha_low_reg;
    logic [CFG_BITS-1:0]   alpha_high_reg;

    // sequencer
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] emit_idx_reg, emit_idx_next;
    logic             negative_reg, negative_next;
    logic             sign_pending_reg, sign_pending_next;

    // digit store, least significant first
    logic [DIGIT_BITS-1:0] digit_buf_reg [DIGIT_SLOTS];

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0] char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 err_reg, err_next;

    logic                  setting_bad;
    logic                  accept;
    logic                  out_free;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quotient;
    div_status_t           div_status;
    logic                  buf_we;
    logic [CNT_W-1:0]      count_inc;
    logic [CNT_W-1:0]      emit_prev;
    logic [DIGIT_BITS-1:0] emit_digit;

    sitrd_check #(
        .MAX_RADIX (MAX_RADIX)
    ) u_check (
        .radix         (radix_reg),
        .alphabet_low  (alpha_low_reg),
        .alphabet_high (alpha_high_reg),
        .invalid       (setting_bad)
    );

    sitrd_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (radix_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // config writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RADIX_RESET;
            alpha_low_reg  <= ALPHA_LOW_RESET;
            alpha_high_reg <= ALPHA_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIX:      radix_reg      <= cfg_data[RADIX_BITS-1:0];
                REG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                REG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // two's-complement magnitude; the most negative value maps to itself
    assign raw = value;
    assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

    assign count_inc  = count_reg + CNT_W'(1);
    assign emit_prev  = emit_idx_reg - CNT_W'(1);
    assign emit_digit = digit_buf_reg[emit_prev[IDX_W-1:0]];

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        emit_idx_next     = emit_idx_reg;
        negative_next     = negative_reg;
        sign_pending_next = sign_pending_reg;
        div_start         = 1'b0;
        div_dividend      = div_quotient;
        buf_we            = 1'b0;

        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        err_next       = err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (setting_bad)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        negative_next = raw[VALUE_BITS-1];
                        count_next    = '0;
                        div_start     = 1'b1;
                        div_dividend  = mag;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    buf_we     = 1'b1;
                    count_next = count_inc;
                    if (div_quotient != '0 && count_inc < CNT_W'(DIGIT_SLOTS))
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        emit_idx_next     = count_inc;
                        sign_pending_next = negative_reg;
                        state_next        = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    err_next       = 1'b0;
                    if (sign_pending_reg)
                    begin
                        char_next         = CHAR_MINUS;
                        last_next         = 1'b0;
                        sign_pending_next = 1'b0;
                    end
                    else
                    begin
                        char_next     = alpha_char(alpha_low_reg, alpha_high_reg, emit_digit);
                        last_next     = (emit_idx_reg == CNT_W'(1));
                        emit_idx_next = emit_prev;
                        if (emit_idx_reg == CNT_W'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_NUL;
                    last_next      = 1'b1;
                    err_next       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            emit_idx_reg     <= '0;
            negative_reg     <= 1'b0;
            sign_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            emit_idx_reg     <= emit_idx_next;
            negative_reg     <= negative_next;
            sign_pending_reg <= sign_pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        err_reg  <= err_next;
        if (buf_we)
        begin
            digit_buf_reg[count_reg[IDX_W-1:0]] <= div_status.remainder;
        end
    end

    assign out_valid    = out_valid_reg;
    assign character    = char_reg;
    assign last         = last_reg;
    assign invalid_base = err_reg;

endmodule
